// File: src/gbts_pkg.sv
// Shared types and constants for the gap buffer text store.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package gbts_pkg;

  // Default number of character cells
  localparam int CAPACITY_DEF = 64;

  // Byte held by every cell after reset, and the reset value of fill_char
  localparam logic [7:0] FILL_RESET = 8'd95;

  // Packed stream widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  // Request commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NO_DEL = 2'd2
  } stat_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEEK,
    ST_FETCH,
    ST_COPY,
    ST_OP,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;          // capture the accepted request
    logic clear_step;    // write one cell of the post-reset clearing pass
    logic step_read;     // read shift source, write fill into it
    logic step_copy;     // write fetched byte to shift target, move edges
    logic step_relabel;  // move edges across an empty gap
    logic do_op;         // insert, delete or issue the cell read
    logic load_out;      // load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;    // clearing pass at its last cell
    logic is_read;       // held request is a cell read
    logic at_target;     // gap sits at the requested position
    logic gap_open;      // gap holds at least one cell
    logic out_busy;      // result register occupied and not taken this cycle
  } dp_stat_t;

endpackage

// File: src/gbts_ctrl.sv
// Controller state machine of the gap buffer text store.
// Sequences clearing, gap shifting, the command itself and the result.
// Depends on gbts_pkg.
module gbts_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  gbts_pkg::dp_stat_t   stat,
  output gbts_pkg::ctrl_cmd_t  cmd
);

  gbts_pkg::state_t state;
  gbts_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbts_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      gbts_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = gbts_pkg::ST_IDLE;
        end
      end
      gbts_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = gbts_pkg::ST_SEEK;
        end
      end
      gbts_pkg::ST_SEEK: begin
        // reads never move the gap
        if (stat.is_read || stat.at_target) begin
          state_next = gbts_pkg::ST_OP;
        end else if (stat.gap_open) begin
          state_next = gbts_pkg::ST_FETCH;
        end else begin
          cmd.step_relabel = 1'b1;
        end
      end
      gbts_pkg::ST_FETCH: begin
        cmd.step_read = 1'b1;
        state_next    = gbts_pkg::ST_COPY;
      end
      gbts_pkg::ST_COPY: begin
        cmd.step_copy = 1'b1;
        state_next    = gbts_pkg::ST_SEEK;
      end
      gbts_pkg::ST_OP: begin
        cmd.do_op  = 1'b1;
        state_next = gbts_pkg::ST_RESULT;
      end
      gbts_pkg::ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = gbts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/gbts_dp.sv
// Datapath of the gap buffer text store: cell memory, gap edges, request
// and result registers. Driven by gbts_ctrl. Depends on gbts_pkg.
module gbts_dp #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gbts_pkg::IN_W-1:0]   s_tdata,
  input  logic                        cfg_valid,
  input  logic [7:0]                  cfg_data,
  input  gbts_pkg::ctrl_cmd_t         cmd,
  output gbts_pkg::dp_stat_t          stat,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [gbts_pkg::OUT_W-1:0]  m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int EW = $clog2(CAPACITY + 1);
  localparam int CW = (EW > 7) ? EW : 7;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);
  localparam logic [EW-1:0] CAP_E     = EW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

  // Cell memory and registered read data
  logic [7:0]      mem [CAPACITY];
  logic [7:0]      rdata;

  // Gap edges: left is the first gap cell, rp1 is one past the last gap cell
  logic [EW-1:0]   left;
  logic [EW-1:0]   rp1;

  logic [7:0]      fill_char;
  logic [AW-1:0]   clr_cnt;

  // Held request
  gbts_pkg::cmd_t  op_cmd;
  logic [EW-1:0]   target;
  logic [7:0]      op_char;
  logic [5:0]      op_ridx;
  gbts_pkg::stat_t op_status;
  logic            rd_hit;

  // Result register
  logic                       out_valid;
  logic [gbts_pkg::OUT_W-1:0] out_data;

  // Request fields
  logic [1:0] in_command;
  logic [6:0] in_position;
  logic [7:0] in_char;
  logic [5:0] in_ridx;
  assign in_command  = s_tdata[1:0];
  assign in_position = s_tdata[8:2];
  assign in_char     = s_tdata[16:9];
  assign in_ridx     = s_tdata[22:17];

  // Gap geometry
  logic [CW-1:0] tl;
  logic [CW-1:0] pos_ext;
  logic [EW-1:0] target_next;
  logic          seek_down;
  logic          gap_open;
  logic          full;
  logic          at_end;
  logic [EW-1:0] left_m1;
  logic [EW-1:0] rp1_m1;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic [CW-1:0] ridx_ext;
  logic          ridx_hit;

  assign tl          = CAP_C - CW'(rp1) + CW'(left);
  assign pos_ext     = CW'(in_position);
  assign target_next = (pos_ext > tl) ? EW'(tl) : EW'(pos_ext);
  assign seek_down   = target < left;
  assign gap_open    = rp1 > left;
  assign full        = rp1 == left;
  assign at_end      = rp1 == CAP_E;
  assign left_m1     = left - EW'(1);
  assign rp1_m1      = rp1 - EW'(1);
  assign src_addr    = seek_down ? left_m1[AW-1:0] : rp1[AW-1:0];
  assign dst_addr    = seek_down ? rp1_m1[AW-1:0] : left[AW-1:0];
  assign ridx_ext    = CW'(op_ridx);
  assign ridx_hit    = ridx_ext < CAP_C;

  // Memory port select
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          re;
  logic [AW-1:0] raddr;

  always_comb begin
    we    = 1'b0;
    waddr = src_addr;
    wdata = fill_char;
    re    = 1'b0;
    raddr = src_addr;
    if (cmd.clear_step) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = gbts_pkg::FILL_RESET;
    end else if (cmd.step_read) begin
      // read-first: the old byte comes out while fill goes in
      we = 1'b1;
      re = 1'b1;
    end else if (cmd.step_copy) begin
      we    = 1'b1;
      waddr = dst_addr;
      wdata = rdata;
    end else if (cmd.do_op) begin
      case (op_cmd)
        gbts_pkg::CMD_INSERT: begin
          we    = !full;
          waddr = left[AW-1:0];
          wdata = op_char;
        end
        gbts_pkg::CMD_DELETE: begin
          we    = !at_end;
          waddr = rp1[AW-1:0];
        end
        gbts_pkg::CMD_READ: begin
          re    = ridx_hit;
          raddr = ridx_ext[AW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Gap edges, fill byte and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      rp1       <= CAP_E;
      fill_char <= gbts_pkg::FILL_RESET;
      clr_cnt   <= '0;
    end else begin
      if (cfg_valid) begin
        fill_char <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.step_copy || cmd.step_relabel) begin
        if (seek_down) begin
          left <= left_m1;
          rp1  <= rp1_m1;
        end else begin
          left <= left + EW'(1);
          rp1  <= rp1 + EW'(1);
        end
      end else if (cmd.do_op) begin
        if (op_cmd == gbts_pkg::CMD_INSERT && !full) begin
          left <= left + EW'(1);
        end
        if (op_cmd == gbts_pkg::CMD_DELETE && !at_end) begin
          rp1 <= rp1 + EW'(1);
        end
      end
    end
  end

  // Held request and command status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd  <= gbts_pkg::cmd_t'(in_command);
      target  <= target_next;
      op_char <= in_char;
      op_ridx <= in_ridx;
    end
    if (cmd.do_op) begin
      rd_hit <= (op_cmd == gbts_pkg::CMD_READ) && ridx_hit;
      if (op_cmd == gbts_pkg::CMD_INSERT && full) begin
        op_status <= gbts_pkg::STAT_FULL;
      end else if (op_cmd == gbts_pkg::CMD_DELETE && at_end) begin
        op_status <= gbts_pkg::STAT_NO_DEL;
      end else begin
        op_status <= gbts_pkg::STAT_OK;
      end
    end
  end

  // Result packing
  logic [CW-1:0] left_c;
  logic [CW-1:0] last_c;
  logic [7:0]    rd_out;
  assign left_c = CW'(left);
  assign last_c = CW'(rp1) - CW'(1);
  assign rd_out = rd_hit ? rdata : 8'd0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {1'b0, tl[6:0], last_c[6:0], left_c[6:0], rd_out, op_status};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign stat.clear_last = clr_cnt == LAST_ADDR;
  assign stat.is_read    = op_cmd == gbts_pkg::CMD_READ;
  assign stat.at_target  = target == left;
  assign stat.gap_open   = gap_open;
  assign stat.out_busy   = out_valid && !m_tready;

endmodule

// File: src/gap_buffer_text_store_core.sv
// Top level of the gap buffer text store: controller plus datapath.
// Depends on gbts_pkg, gbts_ctrl and gbts_dp.
//
// A gap buffer of CAPACITY byte cells whose gap is the cursor. After reset the
// block runs a clearing pass that writes 95 into every cell; no request is
// taken during it, while fill_char writes on the cfg channel are taken at any
// time outside reset (cfg_ready is high whenever rst is low). One request is
// worked on at a time. After a request is accepted, the gap is shifted one
// character at a time by check, fetch and copy steps while it holds cells, or
// relabelled one position at a time when the buffer is full; then the command
// is done and its result is loaded. The next request can be taken in the cycle
// after the result is loaded. Fetch and copy are separate steps since the cell
// memory has a registered read and does one read and one write per cycle.
// Reads skip the gap shift. The next request is taken while a result still
// waits in the output register.
module gap_buffer_text_store_core #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [1:0] command, [8:2] position, [16:9] char_in, [22:17] read_index, [23] zero
  input  logic [gbts_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [1:0] status, [9:2] read_data, [16:10] gap_start, [23:17] gap_last,
  // [30:24] text_length, [31] zero
  output logic [gbts_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data
);

  gbts_pkg::ctrl_cmd_t cmd;
  gbts_pkg::dp_stat_t  stat;

  assign cfg_ready = !rst;

  gbts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbts_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// File: src/gbts_checker.sv
// Port-level checks for the gap buffer text store, bound to the top level.
// Depends on gbts_pkg and gap_buffer_text_store_core.
module gbts_checker #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [gbts_pkg::OUT_W-1:0]  m_tdata
);

  logic [6:0] gap_start;
  logic [6:0] gap_last;
  logic [6:0] text_length;
  logic [6:0] last_expect;
  logic [6:0] start_m1;

  assign gap_start   = m_tdata[16:10];
  assign gap_last    = m_tdata[23:17];
  assign text_length = m_tdata[30:24];
  assign last_expect = gap_start + 7'(CAPACITY) - text_length - 7'd1;
  assign start_m1    = gap_start - 7'd1;

  // A result held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Gap bounds and text length describe the same buffer
  a_geometry: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> gap_last == last_expect)
    else $error("gap bounds disagree with text length");

  // A full report means the gap is empty
  a_full_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == gbts_pkg::STAT_FULL |-> gap_last == start_m1)
    else $error("full status with a non-empty gap");

  // One request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

endmodule

bind gap_buffer_text_store_core gbts_checker #(
  .CAPACITY (CAPACITY)
) u_gbts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/sv/gap_buffer_text_store_checker.sv
// Checker for the gap buffer text store: watches the request, result and
// fill_char channels, predicts every result and compares it field by field.
// Depends on gbts_pkg.
module gap_buffer_text_store_checker
  import gbts_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  output int               errors,
  output int               pending
);

  // Request layout, lowest field last
  typedef struct packed {
    logic       pad;
    logic [5:0] read_index;
    logic [7:0] char_in;
    logic [6:0] position;
    cmd_t       command;
  } edit_req_t;

  // Result layout, lowest field last
  typedef struct packed {
    logic       pad;
    logic [6:0] text_length;
    logic [6:0] gap_last;
    logic [6:0] gap_start;
    logic [7:0] read_data;
    stat_t      status;
  } edit_res_t;

  // Shadow copy of the text store
  logic [7:0] cells [CAPACITY];
  int         gap_lo;
  int         gap_hi;
  logic [7:0] fill_byte;
  edit_res_t  expected_results [$];

  function automatic int text_len();
    return CAPACITY - (gap_hi - gap_lo + 1);
  endfunction

  // Walk the gap one cell at a time; an empty gap only moves its label
  function automatic void slide_gap(input int target);
    bit gap_open;
    while (target < gap_lo) begin
      gap_open = (gap_hi >= gap_lo);
      gap_lo--;
      gap_hi--;
      if (gap_open) begin
        cells[gap_hi + 1] = cells[gap_lo];
        cells[gap_lo]     = fill_byte;
      end
    end
    while (target > gap_lo) begin
      gap_open = (gap_hi >= gap_lo);
      gap_lo++;
      gap_hi++;
      if (gap_open) begin
        cells[gap_lo - 1] = cells[gap_hi];
        cells[gap_hi]     = fill_byte;
      end
    end
  endfunction

  // Apply one request to the shadow store and build its result
  function automatic edit_res_t edit_text(input edit_req_t rq);
    edit_res_t r;
    int        target;
    r        = '0;
    r.status = STAT_OK;
    target   = rq.position;
    if (target > text_len()) target = text_len();
    case (rq.command)
      CMD_INSERT: begin
        slide_gap(target);
        if (gap_hi < gap_lo) begin
          r.status = STAT_FULL;
        end else begin
          cells[gap_lo] = rq.char_in;
          gap_lo++;
        end
      end
      CMD_DELETE: begin
        slide_gap(target);
        if (gap_hi + 1 >= CAPACITY) begin
          r.status = STAT_NO_DEL;
        end else begin
          gap_hi++;
          cells[gap_hi] = fill_byte;
        end
      end
      CMD_MOVE: begin
        slide_gap(target);
      end
      default: begin
        if (int'(rq.read_index) < CAPACITY) r.read_data = cells[rq.read_index];
      end
    endcase
    r.gap_start   = gap_lo[6:0];
    r.gap_last    = gap_hi[6:0];
    r.text_length = 7'(text_len());
    return r;
  endfunction

  function automatic int field_differs(input string name, input int want_v, input int got_v);
    if (want_v == got_v) return 0;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
    return 1;
  endfunction

  // Channel monitor: results are retired before new requests are predicted
  always @(posedge clk) begin : watch
    int        bad;
    edit_res_t got;
    edit_res_t want;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) cells[i] = FILL_RESET;
      gap_lo    = 0;
      gap_hi    = CAPACITY - 1;
      fill_byte = FILL_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      bad = 0;
      if (m_tvalid && m_tready) begin
        got = edit_res_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request waiting: expected none, got %h", $time, m_tdata);
          bad++;
        end else begin
          want = expected_results.pop_front();
          bad += field_differs("status", want.status, got.status);
          bad += field_differs("read_data", want.read_data, got.read_data);
          bad += field_differs("gap_start", want.gap_start, got.gap_start);
          bad += field_differs("gap_last", int'($signed(want.gap_last)),
                               int'($signed(got.gap_last)));
          bad += field_differs("text_length", want.text_length, got.text_length);
          bad += field_differs("pad bit", want.pad, got.pad);
        end
      end
      if (cfg_valid && cfg_ready) fill_byte = cfg_data;
      if (s_tvalid && s_tready) expected_results.push_back(edit_text(edit_req_t'(s_tdata)));
      errors  <= errors + bad;
      pending <= expected_results.size();
    end
  end

endmodule

// File: tb/sv/gap_buffer_text_store_core_tb.sv
// Testbench top for the gap buffer text store: clock, reset, request and
// fill_char stimulus, result back-pressure and the verdict.
// Depends on gbts_pkg, gap_buffer_text_store_core and gap_buffer_text_store_checker.
module gap_buffer_text_store_core_tb;
  import gbts_pkg::*;

  localparam int LIMIT       = 800000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * CAPACITY_DEF + 16;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 85;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       cfg_data  = '0;

  int errors;
  int pending;
  int burst_left;
  int hold_ticket;
  int cycles;

  gap_buffer_text_store_core #(
    .CAPACITY(CAPACITY_DEF)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  gap_buffer_text_store_checker #(
    .CAPACITY(CAPACITY_DEF)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result back-pressure: a randomly redrawn mode, plus long holds
  always @(posedge clk) begin : rx_side
    int rx_cnt;
    int rx_mode;
    int hold_seen;
    int hold_left;
    rx_cnt++;
    if (rx_cnt % 256 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        2:       m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= ((rx_cnt % 11) < 5);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** gap_buffer_text_store_core: FAILED **");
      $finish;
    end
  end

  // Offer one request; valid stays high inside a burst, drops for a gap after it
  task automatic send_req(input cmd_t cmd, input int pos, input int ch, input int ridx);
    s_tdata  <= {1'b0, ridx[5:0], ch[7:0], pos[6:0], cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Weighted random request; position mostly 0 to 64, sometimes up to 127
  task automatic random_req(input int w_ins, input int w_del, input int w_mov);
    int   r;
    int   pos;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (r < w_ins) c = CMD_INSERT;
    else if (r < w_ins + w_del) c = CMD_DELETE;
    else if (r < w_ins + w_del + w_mov) c = CMD_MOVE;
    else c = CMD_READ;
    pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 64);
    send_req(c, pos, $urandom_range(0, 255), $urandom_range(0, 63));
  endtask

  // Stop offering and wait until every result is out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_fill(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    burst_left = 6;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: fresh cells, empty delete, clamping, edge bytes, middle edits
    send_req(CMD_READ, 0, 0, 0);
    send_req(CMD_READ, 0, 0, 63);
    send_req(CMD_DELETE, 0, 0, 0);
    send_req(CMD_MOVE, 127, 0, 0);
    send_req(CMD_INSERT, 127, 8'hFF, 0);
    send_req(CMD_INSERT, 0, 8'h00, 0);
    send_req(CMD_INSERT, 1, 8'hA5, 0);
    send_req(CMD_INSERT, 64, 8'h5A, 0);
    send_req(CMD_MOVE, 0, 0, 0);
    send_req(CMD_MOVE, 4, 0, 0);
    send_req(CMD_MOVE, 2, 0, 0);
    send_req(CMD_READ, 0, 0, 1);
    send_req(CMD_READ, 0, 0, 2);
    send_req(CMD_READ, 0, 0, 62);
    send_req(CMD_DELETE, 2, 0, 0);
    send_req(CMD_DELETE, 127, 0, 0);
    send_req(CMD_DELETE, 0, 0, 0);
    send_req(CMD_MOVE, 1, 0, 0);
    send_req(CMD_READ, 0, 0, 0);
    send_req(CMD_READ, 0, 0, 63);
    drain();

    // Fill to capacity, then work on a full buffer where the gap only relabels
    set_fill(8'h00);
    for (int i = 0; i < CAPACITY_DEF + 2; i++)
      send_req(CMD_INSERT, $urandom_range(0, 64), $urandom_range(0, 255), 0);
    send_req(CMD_MOVE, 0, 0, 0);
    send_req(CMD_MOVE, 64, 0, 0);
    send_req(CMD_INSERT, 30, 8'h41, 0);
    send_req(CMD_DELETE, 127, 0, 0);
    send_req(CMD_READ, 0, 0, 0);
    send_req(CMD_READ, 0, 0, 63);
    send_req(CMD_MOVE, 17, 0, 0);
    for (int i = 0; i < 6; i++) send_req(CMD_DELETE, $urandom_range(0, 64), 0, 0);
    for (int i = 0; i < 6; i++) send_req(CMD_READ, 0, 0, $urandom_range(0, 63));

    // Random phases: growth and shrink alternate, fill_char changes in between
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0:       set_fill(8'hFF);
        2:       set_fill(8'h00);
        3:       set_fill(FILL_RESET);
        default: set_fill(8'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result stall while requests keep coming
        if ((ph == 2 || ph == 5) && i == 20) hold_ticket <= hold_ticket + 1;
        if (ph % 2 == 0) random_req(50, 20, 10);
        else random_req(15, 45, 15);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("** gap_buffer_text_store_core: PASSED **");
    end else begin
      $display("** gap_buffer_text_store_core: FAILED **");
    end
    $finish;
  end

endmodule
